>>> src/bdar_pkg.sv
package bdar_pkg;

	localparam int DLY_W      = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;

	localparam logic [1:0] ACT_START  = 2'd0;
	localparam logic [1:0] ACT_SAMPLE = 2'd1;
	localparam logic [1:0] ACT_POP    = 2'd2;

	localparam logic [1:0] KIND_NONE     = 2'd0;
	localparam logic [1:0] KIND_PRESSED  = 2'd1;
	localparam logic [1:0] KIND_RELEASED = 2'd2;
	localparam logic [1:0] KIND_REPEAT   = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TIME = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PERIOD = 2'd2;

	localparam logic [DLY_W-1:0] DEBOUNCE_RESET = 16'd35;
	localparam logic [DLY_W-1:0] REPEAT_RESET   = 16'd250;

	typedef logic [1:0] kind_t;

	typedef struct packed {
		logic trans;
		logic pressed;
		logic rep;
	} offer_t;

endpackage

>>> src/bdar_cell.sv
module bdar_cell #(
	parameter int STAMP_W = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      sample,
	input  logic                      level,
	input  logic [STAMP_W-1:0]        now,
	input  logic [bdar_pkg::DLY_W-1:0] debounce,
	input  logic [bdar_pkg::DLY_W-1:0] rpt,
	output logic                      stable_nxt,
	output bdar_pkg::offer_t          offer
);
	import bdar_pkg::*;

	logic               last_q;
	logic               stable_q;
	logic [STAMP_W-1:0] change_stamp_q;
	logic [STAMP_W-1:0] repeat_stamp_q;

	logic               last_nxt;
	logic [STAMP_W-1:0] cs_nxt;
	logic [STAMP_W-1:0] rs_mid;
	logic [STAMP_W-1:0] rs_nxt;
	logic [STAMP_W-1:0] held;
	logic [STAMP_W-1:0] since_rep;
	logic               trans;
	logic               rep;

	always_comb begin
		last_nxt   = last_q;
		cs_nxt     = change_stamp_q;
		rs_mid     = repeat_stamp_q;
		rs_nxt     = repeat_stamp_q;
		stable_nxt = stable_q;
		trans      = 1'b0;
		rep        = 1'b0;
		held       = now - cs_nxt;
		since_rep  = now - rs_mid;
		if (start) begin
			last_nxt   = level;
			stable_nxt = level;
			cs_nxt     = now;
			rs_nxt     = '0;
		end else if (sample) begin
			last_nxt = level;
			if (level != last_q) begin
				cs_nxt = now;
			end
			held  = now - cs_nxt;
			trans = (held >= STAMP_W'(debounce)) && (level != stable_q);
			if (trans) begin
				stable_nxt = level;
				rs_mid     = now;
			end
			since_rep = now - rs_mid;
			rep       = stable_nxt && (since_rep >= STAMP_W'(rpt));
			rs_nxt    = rep ? now : rs_mid;
		end
	end

	assign offer.trans   = trans;
	assign offer.pressed = level;
	assign offer.rep     = rep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q         <= 1'b0;
			stable_q       <= 1'b0;
			change_stamp_q <= '0;
			repeat_stamp_q <= '0;
		end else begin
			last_q         <= last_nxt;
			stable_q       <= stable_nxt;
			change_stamp_q <= cs_nxt;
			repeat_stamp_q <= rs_nxt;
		end
	end

	ap_start_aligns: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (last_q == stable_q) && (repeat_stamp_q == '0))
		else $error("Start did not align the sampled and stable levels.");

	ap_rep_needs_press: assert property (@(posedge clk) disable iff (!arst_n)
		rep |-> stable_nxt)
		else $error("Repeat offered for a button that is not stably pressed.");

	ap_trans_flips: assert property (@(posedge clk) disable iff (!arst_n)
		trans |=> (stable_q != $past(stable_q)))
		else $error("Transition offered without a change of the stable level.");

endmodule

>>> src/bdar_evslot.sv
module bdar_evslot #(
	parameter int NUM_BUTTONS = 5,
	parameter int BTN_W       = 3
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               sample,
	input  logic                               pop,
	input  bdar_pkg::offer_t [NUM_BUTTONS-1:0] offers,
	output logic [BTN_W-1:0]                   event_button,
	output bdar_pkg::kind_t                    event_kind
);
	import bdar_pkg::*;

	localparam logic [BTN_W-1:0] BTN_NONE = BTN_W'(NUM_BUTTONS);

	logic [BTN_W-1:0] slot_button_q;
	kind_t            slot_kind_q;
	logic             pick_any;
	logic [BTN_W-1:0] pick_btn;
	kind_t            pick_kind;

	always_comb begin
		pick_any  = 1'b0;
		pick_btn  = BTN_NONE;
		pick_kind = KIND_NONE;
		for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
			if (offers[i].trans) begin
				pick_any  = 1'b1;
				pick_btn  = BTN_W'(i);
				pick_kind = offers[i].pressed ? KIND_PRESSED : KIND_RELEASED;
			end else if (offers[i].rep) begin
				pick_any  = 1'b1;
				pick_btn  = BTN_W'(i);
				pick_kind = KIND_REPEAT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_button_q <= BTN_NONE;
			slot_kind_q   <= KIND_NONE;
		end else if (pop) begin
			slot_button_q <= BTN_NONE;
			slot_kind_q   <= KIND_NONE;
		end else if (sample && (slot_kind_q == KIND_NONE) && pick_any) begin
			slot_button_q <= pick_btn;
			slot_kind_q   <= pick_kind;
		end
	end

	assign event_button = pop ? slot_button_q : BTN_NONE;
	assign event_kind   = pop ? slot_kind_q : KIND_NONE;

	ap_pop_empties: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (slot_kind_q == KIND_NONE) && (slot_button_q == BTN_NONE))
		else $error("Slot not empty after a pop.");

	ap_first_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(slot_kind_q != KIND_NONE) && !pop |=> $stable(slot_kind_q) && $stable(slot_button_q))
		else $error("A held event was overwritten.");

	ap_none_pairs: assert property (@(posedge clk) disable iff (!arst_n)
		(slot_kind_q == KIND_NONE) == (slot_button_q == BTN_NONE))
		else $error("Slot button and kind disagree on emptiness.");

endmodule

>>> src/button_debounce_auto_repeat_unit.sv
// Debounce with auto-repeat for a row of push buttons.
// Requests arrive on the input channel (in_valid, in_stall) carrying an action,
// a wrapping millisecond timestamp, the raw pin levels and a button to query.
// Start captures the levels as stable, sample runs the debounce and repeat
// timers and may fill the single event slot, and pop returns and empties it.
// Every request gives exactly one result on the output channel
// (out_valid, out_stall): the popped event, the stable mask and the answer to
// the query, all taken after that request's update.
// A request is registered in the input register on acceptance and processed
// once the result register is empty or being read, where its result is
// registered in the result register that drives out_valid.
// One request is taken per cycle unless the receiver stalls; the rate is set
// by the single pass through the per-button timer compares and the priority
// pick of the event slot. When the receiver stalls, the result register holds
// and one more request may wait in the input register; beyond that in_stall is raised.
// Reset clears all buttons to released, empties the slot and loads the
// polarity, debounce and repeat registers with their defaults. The user must
// write via cfg_we, cfg_index, cfg_data with no request in flight; unchecked.
module button_debounce_auto_repeat_unit #(
	parameter int NUM_BUTTONS = 5,
	parameter int STAMP_WIDTH = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [1:0]                            action,
	input  logic [STAMP_WIDTH-1:0]                now_ms,
	input  logic [NUM_BUTTONS-1:0]                raw_levels,
	input  logic [$clog2(NUM_BUTTONS+1)-1:0]      query_button,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [$clog2(NUM_BUTTONS+1)-1:0]      event_button,
	output logic [1:0]                            event_kind,
	output logic [NUM_BUTTONS-1:0]                stable_mask,
	output logic                                  query_pressed,
	input  logic                                  cfg_we,
	input  logic [bdar_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [bdar_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import bdar_pkg::*;

	localparam int BTN_W = $clog2(NUM_BUTTONS + 1);

	logic [NUM_BUTTONS-1:0] active_low_q;
	logic [DLY_W-1:0]       debounce_q;
	logic [DLY_W-1:0]       repeat_q;

	logic                   valid_s1;
	logic [1:0]             action_s1;
	logic [STAMP_WIDTH-1:0] now_s1;
	logic [NUM_BUTTONS-1:0] raw_s1;
	logic [BTN_W-1:0]       query_s1;

	logic                   valid_s2;
	logic [BTN_W-1:0]       event_button_s2;
	kind_t                  event_kind_s2;
	logic [NUM_BUTTONS-1:0] stable_s2;
	logic                   query_pressed_s2;

	logic                   accept;
	logic                   adv_s1;
	logic                   step;
	logic                   do_start;
	logic                   do_sample;
	logic                   do_pop;
	logic [NUM_BUTTONS-1:0] levels;
	logic [NUM_BUTTONS-1:0] stable_nxt;
	offer_t [NUM_BUTTONS-1:0] offers;
	logic [BTN_W-1:0]       ev_button;
	kind_t                  ev_kind;
	logic                   query_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_low_q <= '1;
			debounce_q   <= DEBOUNCE_RESET;
			repeat_q     <= REPEAT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ACTIVE_LOW:    active_low_q <= cfg_data[NUM_BUTTONS-1:0];
				REG_DEBOUNCE_TIME: debounce_q   <= cfg_data[DLY_W-1:0];
				REG_REPEAT_PERIOD: repeat_q     <= cfg_data[DLY_W-1:0];
				default: ;
			endcase
		end
	end

	assign adv_s1   = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv_s1;
	assign accept   = in_valid && !in_stall;
	assign step     = valid_s1 && adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !adv_s1);
			valid_s2 <= step || (valid_s2 && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= action;
			now_s1    <= now_ms;
			raw_s1    <= raw_levels;
			query_s1  <= query_button;
		end
	end

	assign do_start  = step && (action_s1 == ACT_START);
	assign do_sample = step && (action_s1 == ACT_SAMPLE);
	assign do_pop    = step && (action_s1 == ACT_POP);
	assign levels    = raw_s1 ^ active_low_q;

	for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_btn
		bdar_cell #(
			.STAMP_W (STAMP_WIDTH)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.start      (do_start),
			.sample     (do_sample),
			.level      (levels[g]),
			.now        (now_s1),
			.debounce   (debounce_q),
			.rpt        (repeat_q),
			.stable_nxt (stable_nxt[g]),
			.offer      (offers[g])
		);
	end

	bdar_evslot #(
		.NUM_BUTTONS (NUM_BUTTONS),
		.BTN_W       (BTN_W)
	) u_evslot (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample       (do_sample),
		.pop          (do_pop),
		.offers       (offers),
		.event_button (ev_button),
		.event_kind   (ev_kind)
	);

	always_comb begin
		query_hit = 1'b0;
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			if (query_s1 == BTN_W'(i)) begin
				query_hit = stable_nxt[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			event_button_s2  <= ev_button;
			event_kind_s2    <= ev_kind;
			stable_s2        <= stable_nxt;
			query_pressed_s2 <= query_hit;
		end
	end

	assign out_valid     = valid_s2;
	assign event_button  = event_button_s2;
	assign event_kind    = event_kind_s2;
	assign stable_mask   = stable_s2;
	assign query_pressed = query_pressed_s2;

	ap_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1)
		else $error("Input stage dropped a waiting request.");

	ap_step_fills: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> valid_s2)
		else $error("Processed request did not reach the result register.");

	ap_event_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((event_kind == KIND_NONE) == (event_button == BTN_W'(NUM_BUTTONS))))
		else $error("Result event button and kind disagree.");

endmodule

>>> dv/tb_button_debounce_auto_repeat_unit.sv
module tb_button_debounce_auto_repeat_unit;

	import bdar_pkg::*;

	localparam int NUM_BUTTONS = 5;
	localparam int STAMP_WIDTH = 32;
	localparam int QUERY_W = $clog2(NUM_BUTTONS + 1);
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam logic [QUERY_W-1:0] NO_BUTTON = 3'd5;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_OFF_CYCLES = 60;
	localparam int PHASE_REQUESTS = 175;

	typedef struct packed {
		logic [QUERY_W-1:0]     button;
		kind_t                  kind;
		logic [NUM_BUTTONS-1:0] mask;
		logic                   query;
	} button_report_t;

	class button_event_tracker;
		bit [NUM_BUTTONS-1:0] polarity;
		bit [DLY_W-1:0]       settle_ms;
		bit [DLY_W-1:0]       repeat_ms;
		bit [NUM_BUTTONS-1:0] stable;
		bit [NUM_BUTTONS-1:0] sampled;
		bit [STAMP_WIDTH-1:0] change_at [NUM_BUTTONS];
		bit [STAMP_WIDTH-1:0] repeat_at [NUM_BUTTONS];
		bit [QUERY_W-1:0]     slot_button;
		kind_t                slot_kind;
		button_report_t       due_reports [$];
		int                   errors;

		function new();
			polarity = '1;
			settle_ms = DEBOUNCE_RESET;
			repeat_ms = REPEAT_RESET;
			stable = '0;
			sampled = '0;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				change_at[i] = '0;
				repeat_at[i] = '0;
			end
			slot_button = NO_BUTTON;
			slot_kind = KIND_NONE;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_ACTIVE_LOW: polarity = data[NUM_BUTTONS-1:0];
				REG_DEBOUNCE_TIME: settle_ms = data;
				REG_REPEAT_PERIOD: repeat_ms = data;
				default: ;
			endcase
		endfunction

		function void offer(int btn, kind_t kind);
			if (slot_kind == KIND_NONE) begin
				slot_button = btn[QUERY_W-1:0];
				slot_kind = kind;
			end
		endfunction

		function void note_request(logic [1:0] act, logic [STAMP_WIDTH-1:0] now,
				logic [NUM_BUTTONS-1:0] raw, logic [QUERY_W-1:0] query);
			bit [NUM_BUTTONS-1:0] levels;
			bit [STAMP_WIDTH-1:0] held;
			button_report_t       r;
			levels = raw ^ polarity;
			r.button = NO_BUTTON;
			r.kind = KIND_NONE;
			case (act)
				ACT_START: begin
					sampled = levels;
					stable = levels;
					for (int i = 0; i < NUM_BUTTONS; i++) begin
						change_at[i] = now;
						repeat_at[i] = '0;
					end
				end
				ACT_SAMPLE: begin
					for (int i = 0; i < NUM_BUTTONS; i++) begin
						if (levels[i] != sampled[i]) begin
							sampled[i] = levels[i];
							change_at[i] = now;
						end
						held = now - change_at[i];
						if (held >= {16'd0, settle_ms} && levels[i] != stable[i]) begin
							stable[i] = levels[i];
							offer(i, levels[i] ? KIND_PRESSED : KIND_RELEASED);
							repeat_at[i] = now;
						end
						held = now - repeat_at[i];
						if (stable[i] && held >= {16'd0, repeat_ms}) begin
							repeat_at[i] = now;
							offer(i, KIND_REPEAT);
						end
					end
				end
				ACT_POP: begin
					r.button = slot_button;
					r.kind = slot_kind;
					slot_button = NO_BUTTON;
					slot_kind = KIND_NONE;
				end
				default: ;
			endcase
			r.mask = stable;
			r.query = (query < NUM_BUTTONS) ? stable[query] : 1'b0;
			due_reports.push_back(r);
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		task check_result(logic [QUERY_W-1:0] button, kind_t kind,
				logic [NUM_BUTTONS-1:0] mask, logic query);
			button_report_t want;
			if (due_reports.size() == 0) begin
				report($sformatf("result with no request pending, mask %0h", mask));
			end else begin
				want = due_reports.pop_front();
				if (button !== want.button)
					report($sformatf("event_button %0d, expected %0d", button, want.button));
				if (kind !== want.kind)
					report($sformatf("event_kind %0d, expected %0d", kind, want.kind));
				if (mask !== want.mask)
					report($sformatf("stable_mask %0h, expected %0h", mask, want.mask));
				if (query !== want.query)
					report($sformatf("query_pressed %0b, expected %0b", query, want.query));
			end
		endtask
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	logic [1:0]             action;
	logic [STAMP_WIDTH-1:0] now_ms;
	logic [NUM_BUTTONS-1:0] raw_levels;
	logic [QUERY_W-1:0]     query_button;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [QUERY_W-1:0]     event_button;
	logic [1:0]             event_kind;
	logic [NUM_BUTTONS-1:0] stable_mask;
	logic                   query_pressed;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	button_event_tracker    tracker;
	bit                     tx_idle = 1'b0;
	bit                     rx_idle = 1'b0;
	bit                     hold_request = 1'b0;
	int                     cycle_count = 0;
	logic [STAMP_WIDTH-1:0] clock_ms;
	logic [NUM_BUTTONS-1:0] pins;

	button_debounce_auto_repeat_unit #(
		.NUM_BUTTONS(NUM_BUTTONS),
		.STAMP_WIDTH(STAMP_WIDTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.now_ms(now_ms),
		.raw_levels(raw_levels),
		.query_button(query_button),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.event_button(event_button),
		.event_kind(event_kind),
		.stable_mask(stable_mask),
		.query_pressed(query_pressed),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("button_debounce_auto_repeat_unit verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_result(event_button, event_kind, stable_mask, query_pressed);
	end

	// The long hold-off lets requests pile up inside the block until in_stall rises.
	always begin : rx_side
		int pause;
		@(negedge clk);
		if (hold_request) begin
			hold_request = 1'b0;
			out_stall = 1'b1;
			repeat (HOLD_OFF_CYCLES) @(negedge clk);
		end
		pause = rx_idle ? $urandom_range(0, 3) : 0;
		if (pause > 0) begin
			out_stall = 1'b1;
			repeat (pause) @(negedge clk);
		end
		out_stall = 1'b0;
		do @(posedge clk); while (!(out_valid && arst_n));
	end

	task send_request(logic [1:0] act, logic [STAMP_WIDTH-1:0] now,
			logic [NUM_BUTTONS-1:0] raw, logic [QUERY_W-1:0] query);
		int gap;
		gap = tx_idle ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		action = act;
		now_ms = now;
		raw_levels = raw;
		query_button = query;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		tracker.note_request(act, now, raw, query);
		@(negedge clk);
	endtask

	task drain_results;
		in_valid = 1'b0;
		while (tracker.due_reports.size() != 0) @(negedge clk);
	endtask

	task program_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		tracker.write_reg(idx, data);
	endtask

	task program_timing(logic [CFG_DATA_W-1:0] polarity, logic [CFG_DATA_W-1:0] settle,
			logic [CFG_DATA_W-1:0] period);
		drain_results();
		program_reg(REG_ACTIVE_LOW, polarity);
		program_reg(REG_DEBOUNCE_TIME, settle);
		program_reg(REG_REPEAT_PERIOD, period);
	endtask

	// Levels mostly hold with the odd bounce, so the debounce and repeat timers get to expire.
	task run_button_traffic(int count, int step_max);
		int            pick;
		int            btn;
		logic [1:0]    act;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 3)
				act = ACT_START;
			else if (pick < 28)
				act = ACT_POP;
			else if (pick == 28)
				act = ACT_UNUSED;
			else
				act = ACT_SAMPLE;
			if ($urandom_range(0, 49) == 0)
				clock_ms = $urandom;
			else
				clock_ms = clock_ms + $urandom_range(0, step_max);
			pick = $urandom_range(0, 99);
			if (pick < 4) begin
				pins = NUM_BUTTONS'($urandom);
			end else if (pick < 20) begin
				btn = $urandom_range(0, NUM_BUTTONS - 1);
				pins[btn] = ~pins[btn];
			end
			send_request(act, clock_ms, pins, QUERY_W'($urandom_range(0, 7)));
		end
	endtask

	initial begin
		tracker = new;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_START;
		now_ms = '0;
		raw_levels = '0;
		query_button = '0;
		cfg_we = 1'b0;
		cfg_index = REG_ACTIVE_LOW;
		cfg_data = '0;
		clock_ms = '0;
		pins = '1;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_request(ACT_START, 32'd0, 5'h1F, 3'd0);
		send_request(ACT_SAMPLE, 32'd10, 5'h1E, 3'd0);
		send_request(ACT_SAMPLE, 32'd44, 5'h1E, 3'd0);
		send_request(ACT_SAMPLE, 32'd45, 5'h1E, 3'd0);
		send_request(ACT_POP, 32'd46, 5'h1E, 3'd0);
		send_request(ACT_POP, 32'd47, 5'h1E, 3'd1);
		send_request(ACT_SAMPLE, 32'd295, 5'h1E, 3'd0);
		send_request(ACT_SAMPLE, 32'd300, 5'h00, 3'd7);
		send_request(ACT_SAMPLE, 32'd335, 5'h00, 3'd2);
		send_request(ACT_POP, 32'd336, 5'h00, 3'd4);
		send_request(ACT_SAMPLE, 32'd600, 5'h00, 3'd3);
		send_request(ACT_POP, 32'd601, 5'h00, 3'd5);
		send_request(ACT_SAMPLE, 32'd610, 5'h1F, 3'd0);
		send_request(ACT_SAMPLE, 32'd645, 5'h1F, 3'd6);
		send_request(ACT_POP, 32'd646, 5'h1F, 3'd0);
		send_request(ACT_POP, 32'd647, 5'h1F, 3'd0);
		send_request(ACT_UNUSED, 32'hFFFF_FFFF, 5'h00, 3'd5);
		send_request(ACT_START, 32'hFFFF_FFF0, 5'h0A, 3'd1);
		send_request(ACT_SAMPLE, 32'h0000_0020, 5'h15, 3'd2);
		send_request(ACT_SAMPLE, 32'h0000_0043, 5'h15, 3'd0);
		send_request(ACT_POP, 32'h0000_0044, 5'h15, 3'd7);
		send_request(ACT_SAMPLE, 32'hFFFF_FFFF, 5'h00, 3'd4);

		tx_idle = 1'b1;
		rx_idle = 1'b1;
		clock_ms = 32'd1000;
		pins = '1;
		run_button_traffic(PHASE_REQUESTS, 20);

		program_timing(16'h0000, 16'h0000, 16'h0000);
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		run_button_traffic(PHASE_REQUESTS, 3);

		program_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
		tx_idle = 1'b1;
		run_button_traffic(PHASE_REQUESTS, 12000);

		program_timing(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom_range(1, 20)),
			CFG_DATA_W'($urandom_range(1, 30)));
		tx_idle = 1'b0;
		rx_idle = 1'b1;
		hold_request = 1'b1;
		run_button_traffic(PHASE_REQUESTS, 10);

		program_timing(CFG_DATA_W'($urandom), 16'h0000, CFG_DATA_W'($urandom_range(0, 8)));
		tx_idle = 1'b1;
		run_button_traffic(PHASE_REQUESTS, 5);

		program_timing(CFG_DATA_W'($urandom), DEBOUNCE_RESET, REPEAT_RESET);
		clock_ms = 32'hFFFF_FC00;
		run_button_traffic(PHASE_REQUESTS, 30);

		drain_results();
		repeat (8) @(posedge clk);
		if (tracker.errors == 0)
			$display("button_debounce_auto_repeat_unit verification clean");
		else
			$display("button_debounce_auto_repeat_unit verification failed");
		$finish;
	end

endmodule

>>> sim.f
src/bdar_pkg.sv
src/bdar_cell.sv
src/bdar_evslot.sv
src/button_debounce_auto_repeat_unit.sv
dv/tb_button_debounce_auto_repeat_unit.sv
